/* src/etc_pkg.sv */
// etc_pkg: shared types, constants and register codes for the expiring translation cache.
// Used by every module under src except etc_ram; has no dependencies of its own.
package etc_pkg;

    localparam int BASE_ENTRIES_DEF = 4096;
    localparam int HUGE_ENTRIES_DEF = 4096;
    localparam int QUEUE_DEPTH      = 2;

    localparam int ADDR_W   = 64;
    localparam int PAGE_W   = 52;
    localparam int FRAME_W  = 54;
    localparam int STAMP_W  = 32;
    localparam int BSHIFT_W = 5;
    localparam int HSHIFT_W = 6;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 2;

    localparam int IN_DATA_W  = 192;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;

    localparam logic [BSHIFT_W-1:0] BASE_SHIFT_MIN = 5'd12;
    localparam logic [BSHIFT_W-1:0] BASE_SHIFT_MAX = 5'd30;
    localparam logic [HSHIFT_W-1:0] HUGE_SHIFT_MIN = 6'd13;
    localparam logic [HSHIFT_W-1:0] HUGE_SHIFT_MAX = 6'd40;

    localparam logic [BSHIFT_W-1:0] BASE_SHIFT_RST     = 5'd12;
    localparam logic [HSHIFT_W-1:0] HUGE_SHIFT_RST     = 6'd24;
    localparam logic [CFG_W-1:0]    INSTR_INTERVAL_RST = 32'd10000;
    localparam logic [CFG_W-1:0]    DATA_INTERVAL_RST  = 32'd100;

    localparam int                PRESENT_BIT = 63;
    localparam logic [ADDR_W-1:0] HUGE_FLAGS  = 64'h0000_0000_0042_0000;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_FILL   = 1'b1
    } cmd_t;

    typedef enum logic [IDX_W-1:0] {
        REG_BASE_SHIFT     = 2'd0,
        REG_HUGE_SHIFT     = 2'd1,
        REG_INSTR_INTERVAL = 2'd2,
        REG_DATA_INTERVAL  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } back_state_t;

    // classified item handed from front to back
    typedef struct packed {
        cmd_t                cmd;
        logic [STAMP_W-1:0]  interval;
        logic [PAGE_W-1:0]   bpage;
        logic [PAGE_W-1:0]   hpage;
        logic [BSHIFT_W-1:0] bs;
        logic [HSHIFT_W-1:0] hs;
        logic                present;
        logic                huge;
        logic [FRAME_W-1:0]  frame;
    } work_t;

    // one table entry as stored in RAM
    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  tag;
        logic [FRAME_W-1:0] frame;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

/* src/etc_ram.sv */
// etc_ram: generic single-write, single-read RAM with registered read data.
// No package dependencies.
module etc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/etc_front.sv */
// etc_front: classifies an incoming beat: clamps shifts, forms page numbers,
// picks the lifetime and decodes the fill words. Depends on etc_pkg.
module etc_front (
    input  etc_pkg::cmd_t                 command,
    input  logic [etc_pkg::ADDR_W-1:0]    address,
    input  logic                          iside,
    input  logic [etc_pkg::ADDR_W-1:0]    pagemap_word,
    input  logic [etc_pkg::ADDR_W-1:0]    page_flags,
    input  logic [etc_pkg::BSHIFT_W-1:0]  base_shift,
    input  logic [etc_pkg::HSHIFT_W-1:0]  huge_shift,
    input  logic [etc_pkg::CFG_W-1:0]     instr_interval,
    input  logic [etc_pkg::CFG_W-1:0]     data_interval,
    output etc_pkg::work_t                work
);

    logic [etc_pkg::BSHIFT_W-1:0] bs;
    logic [etc_pkg::HSHIFT_W-1:0] hs;
    logic [etc_pkg::ADDR_W-1:0]   bpage_full;
    logic [etc_pkg::ADDR_W-1:0]   hpage_full;

    always_comb
    begin
        priority if (base_shift < etc_pkg::BASE_SHIFT_MIN)
            bs = etc_pkg::BASE_SHIFT_MIN;
        else if (base_shift > etc_pkg::BASE_SHIFT_MAX)
            bs = etc_pkg::BASE_SHIFT_MAX;
        else
            bs = base_shift;

        priority if (huge_shift < etc_pkg::HUGE_SHIFT_MIN)
            hs = etc_pkg::HUGE_SHIFT_MIN;
        else if (huge_shift > etc_pkg::HUGE_SHIFT_MAX)
            hs = etc_pkg::HUGE_SHIFT_MAX;
        else
            hs = huge_shift;
    end

    // shifts of at least 12 leave at most 52 significant bits
    assign bpage_full = address >> bs;
    assign hpage_full = address >> hs;

    assign work.cmd      = command;
    assign work.interval = iside ? instr_interval : data_interval;
    assign work.bpage    = bpage_full[etc_pkg::PAGE_W-1:0];
    assign work.hpage    = hpage_full[etc_pkg::PAGE_W-1:0];
    assign work.bs       = bs;
    assign work.hs       = hs;
    assign work.present  = pagemap_word[etc_pkg::PRESENT_BIT];
    assign work.huge     = |(page_flags & etc_pkg::HUGE_FLAGS);
    assign work.frame    = pagemap_word[etc_pkg::FRAME_W-1:0];

endmodule

/* src/etc_queue.sv */
// etc_queue: short FIFO of classified items between front and back.
// Depends on etc_pkg (work_t, QUEUE_DEPTH).
module etc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  etc_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output etc_pkg::work_t head
);

    localparam int PTR_W = $clog2(etc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(etc_pkg::QUEUE_DEPTH + 1);

    etc_pkg::work_t   slots_reg [etc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = (count_reg == CNT_W'(etc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

endmodule

/* src/etc_back.sv */
// etc_back: table sequencer. Clears both tables after reset, then reads,
// compares, fills and drives the result register. Depends on etc_pkg, etc_ram.
module etc_back #(
    parameter int BASE_ENTRIES = etc_pkg::BASE_ENTRIES_DEF,
    parameter int HUGE_ENTRIES = etc_pkg::HUGE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  etc_pkg::work_t                   q_head,
    output logic                             q_pop,
    output logic                             clearing,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [etc_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int BI_W    = $clog2(BASE_ENTRIES);
    localparam int HI_W    = $clog2(HUGE_ENTRIES);
    localparam int MAX_E   = (BASE_ENTRIES > HUGE_ENTRIES) ? BASE_ENTRIES : HUGE_ENTRIES;
    localparam int CLR_W   = $clog2(MAX_E);
    localparam int ENTRY_W = $bits(etc_pkg::entry_t);

    etc_pkg::back_state_t state_reg, state_next;
    logic [CLR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    etc_pkg::work_t       work_reg, work_next;
    logic [etc_pkg::STAMP_W-1:0] counter_reg, counter_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          found_reg, found_next;
    logic [etc_pkg::ADDR_W-1:0]    phys_reg, phys_next;
    logic [etc_pkg::HSHIFT_W-1:0]  shift_reg, shift_next;

    logic              base_we, huge_we;
    logic [BI_W-1:0]   base_waddr, base_raddr;
    logic [HI_W-1:0]   huge_waddr, huge_raddr;
    etc_pkg::entry_t   base_wdata, huge_wdata, fill_entry;
    logic [ENTRY_W-1:0] base_rbits, huge_rbits;
    etc_pkg::entry_t   base_rd, huge_rd;

    logic [etc_pkg::STAMP_W-1:0] cnt_inc, base_age, huge_age;
    logic                        has_interval, base_hit, huge_hit;
    logic [etc_pkg::ADDR_W-1:0]  base_phys, huge_phys, fill_phys;

    etc_ram #(.WIDTH(ENTRY_W), .DEPTH(BASE_ENTRIES)) u_base_ram (
        .clk   (clk),
        .we    (base_we),
        .waddr (base_waddr),
        .wdata (base_wdata),
        .raddr (base_raddr),
        .rdata (base_rbits)
    );

    etc_ram #(.WIDTH(ENTRY_W), .DEPTH(HUGE_ENTRIES)) u_huge_ram (
        .clk   (clk),
        .we    (huge_we),
        .waddr (huge_waddr),
        .wdata (huge_wdata),
        .raddr (huge_raddr),
        .rdata (huge_rbits)
    );

    assign base_rd = etc_pkg::entry_t'(base_rbits);
    assign huge_rd = etc_pkg::entry_t'(huge_rbits);

    // hit checks against the registered read data
    assign cnt_inc      = counter_reg + 32'd1;
    assign base_age     = cnt_inc - base_rd.stamp;
    assign huge_age     = cnt_inc - huge_rd.stamp;
    assign has_interval = |work_reg.interval;
    assign base_hit     = base_rd.valid && (base_rd.tag == work_reg.bpage)
                          && (base_age < work_reg.interval);
    assign huge_hit     = huge_rd.valid && (huge_rd.tag == work_reg.hpage)
                          && (huge_age < work_reg.interval);

    // huge hits also scale by the base shift
    assign base_phys = {10'b0, base_rd.frame} << work_reg.bs;
    assign huge_phys = {10'b0, huge_rd.frame} << work_reg.bs;
    assign fill_phys = {10'b0, work_reg.frame} << work_reg.bs;

    assign fill_entry.valid = 1'b1;
    assign fill_entry.tag   = work_reg.huge ? work_reg.hpage : work_reg.bpage;
    assign fill_entry.frame = work_reg.frame;
    assign fill_entry.stamp = counter_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        work_next      = work_reg;
        counter_next   = counter_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        found_next     = found_reg;
        phys_next      = phys_reg;
        shift_next     = shift_reg;
        q_pop          = 1'b0;
        base_we        = 1'b0;
        huge_we        = 1'b0;
        base_waddr     = work_reg.bpage[BI_W-1:0];
        huge_waddr     = work_reg.hpage[HI_W-1:0];
        base_wdata     = fill_entry;
        huge_wdata     = fill_entry;
        base_raddr     = work_reg.bpage[BI_W-1:0];
        huge_raddr     = work_reg.hpage[HI_W-1:0];

        unique case (state_reg)
            etc_pkg::ST_CLEAR:
            begin
                base_we    = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(BASE_ENTRIES));
                huge_we    = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(HUGE_ENTRIES));
                base_waddr = clr_cnt_reg[BI_W-1:0];
                huge_waddr = clr_cnt_reg[HI_W-1:0];
                base_wdata = '0;
                huge_wdata = '0;
                if (clr_cnt_reg == CLR_W'(MAX_E - 1))
                begin
                    state_next = etc_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                end
            end
            etc_pkg::ST_IDLE:
            begin
                // address straight from the queue head so data lands next cycle
                base_raddr = q_head.bpage[BI_W-1:0];
                huge_raddr = q_head.hpage[HI_W-1:0];
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    work_next  = q_head;
                    state_next = etc_pkg::ST_EVAL;
                end
            end
            etc_pkg::ST_EVAL:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    phys_next      = '0;
                    shift_next     = '0;
                    state_next     = etc_pkg::ST_IDLE;
                    if (work_reg.cmd == etc_pkg::CMD_LOOKUP)
                    begin
                        if (has_interval)
                        begin
                            counter_next = cnt_inc;
                            priority if (base_hit)
                            begin
                                found_next = 1'b1;
                                phys_next  = base_phys;
                                shift_next = {1'b0, work_reg.bs};
                            end
                            else if (huge_hit)
                            begin
                                found_next = 1'b1;
                                phys_next  = huge_phys;
                                shift_next = work_reg.hs;
                            end
                            else
                            begin
                                found_next = 1'b0;
                            end
                        end
                    end
                    else if (work_reg.present)
                    begin
                        found_next = 1'b1;
                        phys_next  = fill_phys;
                        shift_next = work_reg.huge ? work_reg.hs : {1'b0, work_reg.bs};
                        base_we    = has_interval && !work_reg.huge;
                        huge_we    = has_interval && work_reg.huge;
                    end
                end
            end
            default:
            begin
                state_next = etc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= etc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        found_reg <= found_next;
        phys_reg  <= phys_next;
        shift_reg <= shift_next;
    end

    assign clearing = (state_reg == etc_pkg::ST_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, shift_reg, phys_reg, found_reg};

endmodule

/* src/expiring_translation_cache.sv */
// expiring_translation_cache: top level; config registers, front classifier,
// item queue and table back end. Depends on etc_pkg, etc_front, etc_queue, etc_back.
//
//  channel | dir | handshake         | payload
//  s       | in  | s_tvalid/s_tready | s_tdata, s_tuser: lookup or fill request
//  m       | out | m_tvalid/m_tready | m_tdata: found, phys_addr, page_shift
//  cfg     | in  | cfg_we            | cfg_index, cfg_data
//
// Each item goes through the back end as a table read (ST_IDLE), then a compare/fill
// (ST_EVAL), set by the registered read of each table RAM; the next read waits for
// the current compare/fill, so a fill is seen by the item right behind it. The queue
// holds 2 items ahead. After reset a clearing pass over max(BASE_ENTRIES, HUGE_ENTRIES)
// entries (4096 by default) runs before s_tready rises. A result waits in the
// output register; the back end stalls on m_tready only when a second result is ready.
module expiring_translation_cache #(
    parameter int BASE_ENTRIES = etc_pkg::BASE_ENTRIES_DEF,
    parameter int HUGE_ENTRIES = etc_pkg::HUGE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [63:0] address, [127:64] pagemap_word, [191:128] page_flags
    input  logic [etc_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] command, [1] iside
    input  logic [etc_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] found, [64:1] phys_addr, [70:65] page_shift, [71] zero
    output logic [etc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [etc_pkg::IDX_W-1:0]         cfg_index,
    input  logic [etc_pkg::CFG_W-1:0]         cfg_data
);

    logic [etc_pkg::BSHIFT_W-1:0] base_shift_reg;
    logic [etc_pkg::HSHIFT_W-1:0] huge_shift_reg;
    logic [etc_pkg::CFG_W-1:0]    instr_interval_reg;
    logic [etc_pkg::CFG_W-1:0]    data_interval_reg;

    etc_pkg::work_t front_work, q_head;
    logic           q_full, q_valid, q_pop, push, clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_shift_reg     <= etc_pkg::BASE_SHIFT_RST;
            huge_shift_reg     <= etc_pkg::HUGE_SHIFT_RST;
            instr_interval_reg <= etc_pkg::INSTR_INTERVAL_RST;
            data_interval_reg  <= etc_pkg::DATA_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (etc_pkg::reg_idx_t'(cfg_index))
                etc_pkg::REG_BASE_SHIFT:
                    base_shift_reg <= cfg_data[etc_pkg::BSHIFT_W-1:0];
                etc_pkg::REG_HUGE_SHIFT:
                    huge_shift_reg <= cfg_data[etc_pkg::HSHIFT_W-1:0];
                etc_pkg::REG_INSTR_INTERVAL:
                    instr_interval_reg <= cfg_data;
                etc_pkg::REG_DATA_INTERVAL:
                    data_interval_reg <= cfg_data;
            endcase
        end
    end

    etc_front u_front (
        .command        (etc_pkg::cmd_t'(s_tuser[0])),
        .address        (s_tdata[63:0]),
        .iside          (s_tuser[1]),
        .pagemap_word   (s_tdata[127:64]),
        .page_flags     (s_tdata[191:128]),
        .base_shift     (base_shift_reg),
        .huge_shift     (huge_shift_reg),
        .instr_interval (instr_interval_reg),
        .data_interval  (data_interval_reg),
        .work           (front_work)
    );

    assign s_tready = !q_full && !clearing;
    assign push     = s_tvalid && s_tready;

    etc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (front_work),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    etc_back #(
        .BASE_ENTRIES (BASE_ENTRIES),
        .HUGE_ENTRIES (HUGE_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
